// File: src/rcsfd_pkg.sv
// Shared types and constants for the servo frame decoder.
// Depends on nothing; the controller, datapath and top level import it.
package rcsfd_pkg;

  localparam int FRAME_BYTES  = 32;
  localparam int MAX_CHANNELS = 14;
  localparam int SUM_BYTES    = 30;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);

  localparam logic [15:0] SUM_INIT = 16'hFFFF;

  // Frame positions with special meaning
  localparam logic [ADDR_W-1:0] POS_FIRST    = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] POS_SECOND   = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] POS_SUM_LO   = ADDR_W'(SUM_BYTES);
  localparam logic [ADDR_W-1:0] POS_SUM_HI   = ADDR_W'(SUM_BYTES + 1);
  localparam logic [ADDR_W-1:0] POS_CH_BASE  = ADDR_W'(2);

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST    = 8'd32;
  localparam logic [7:0] SYNC_SECOND_RST   = 8'd64;
  localparam logic [3:0] CHANNEL_COUNT_RST = 4'd14;
  localparam logic [3:0] MAX_CH_CODE       = 4'(MAX_CHANNELS);

  // Controller -> datapath
  typedef struct packed {
    logic byte_acc;   // input byte accepted this cycle
    logic rd_lo;      // issue read of current channel low byte
    logic rd_hi;      // capture low byte, issue read of high byte
    logic load_out;   // load output register from read data
    logic next_ch;    // advance channel counter
  } rcsfd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_end;  // accepted byte completes the frame
    logic n_zero;     // no channels to emit
    logic ch_last;    // current channel is the final one
    logic out_busy;   // output register holds a result not taken this cycle
  } rcsfd_stat_t;

endpackage

// File: src/rcsfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/rcsfd_ctrl.sv
// Controller for the servo frame decoder: receive / readout sequencing.
// Depends on rcsfd_pkg.
module rcsfd_ctrl import rcsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rcsfd_stat_t stat,
  output rcsfd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_RECV,
    S_RD_LO,
    S_RD_HI,
    S_LOAD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_RECV: begin
        in_ready     = 1'b1;
        cmd.byte_acc = in_valid;
        if (stat.frame_end && !stat.n_zero) begin
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait until the previous result has left the output register
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = stat.ch_last ? S_RECV : S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.next_ch = 1'b1;
          state_nxt   = S_RD_LO;
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/rcsfd_dp.sv
// Datapath for the servo frame decoder: config registers, sync check,
// checksum, frame store and output register. Depends on rcsfd_pkg, rcsfd_ram.
module rcsfd_dp import rcsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [7:0]  in_rx_byte,
  input  rcsfd_cmd_t  cmd,
  output rcsfd_stat_t stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel_index,
  output logic [15:0] out_channel_value,
  output logic        out_frame_ok,
  output logic        out_last
);

  logic [7:0]        sync_first_r, sync_second_r;
  logic [3:0]        channel_count_r;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        sum_lo_r;
  logic              ok_r;
  logic [3:0]        ch_r;
  logic [7:0]        lo_byte_r;
  logic              out_valid_r;
  logic [3:0]        out_index_r;
  logic [15:0]       out_value_r;
  logic              out_ok_r;
  logic              out_last_r;

  logic              store;
  logic [3:0]        n_ch;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // Byte acceptance and checksum
  always_comb begin
    store   = 1'b0;
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (cmd.byte_acc) begin
      priority if (pos_r == POS_FIRST) begin
        store = (in_rx_byte == sync_first_r);
      end else if (pos_r == POS_SECOND) begin
        store = (in_rx_byte == sync_second_r);
        if (!store) begin
          pos_nxt = POS_FIRST;
          sum_nxt = SUM_INIT;
        end
      end else begin
        store = 1'b1;
      end
      if (store) begin
        if (pos_r < POS_SUM_LO) begin
          sum_nxt = sum_r - {8'd0, in_rx_byte};
        end
        if (pos_r == POS_SUM_HI) begin
          pos_nxt = POS_FIRST;
          sum_nxt = SUM_INIT;
        end else begin
          pos_nxt = pos_r + ADDR_W'(1);
        end
      end
    end
  end

  assign n_ch = (channel_count_r > MAX_CH_CODE) ? MAX_CH_CODE : channel_count_r;

  assign stat.frame_end = store && (pos_r == POS_SUM_HI);
  assign stat.n_zero    = (n_ch == 4'd0);
  assign stat.ch_last   = (ch_r == n_ch - 4'd1);
  assign stat.out_busy  = out_valid_r && !out_ready;

  // Channel i: low byte at 2+2i, high byte at 3+2i
  assign rd_addr = {ch_r, cmd.rd_hi} + POS_CH_BASE;

  rcsfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (pos_r),
    .wdata (in_rx_byte),
    .re    (cmd.rd_lo || cmd.rd_hi),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r    <= SYNC_FIRST_RST;
      sync_second_r   <= SYNC_SECOND_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
      pos_r           <= POS_FIRST;
      sum_r           <= SUM_INIT;
      ch_r            <= 4'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SYNC_FIRST:    sync_first_r    <= cfg_data;
          CFG_SYNC_SECOND:   sync_second_r   <= cfg_data;
          CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (stat.frame_end) begin
        ch_r <= 4'd0;
      end else if (cmd.next_ch) begin
        ch_r <= ch_r + 4'd1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (store && pos_r == POS_SUM_LO) begin
      sum_lo_r <= in_rx_byte;
    end
    if (stat.frame_end) begin
      ok_r <= ({in_rx_byte, sum_lo_r} == sum_r);
    end
    if (cmd.rd_hi) begin
      lo_byte_r <= rd_data;
    end
    if (cmd.load_out) begin
      out_index_r <= ch_r;
      out_value_r <= {rd_data, lo_byte_r};
      out_ok_r    <= ok_r;
      out_last_r  <= stat.ch_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_index_r;
  assign out_channel_value = out_value_r;
  assign out_frame_ok      = out_ok_r;
  assign out_last          = out_last_r;

endmodule

// File: src/rc_servo_frame_decoder.sv
// Servo-link frame decoder: 32-byte frames, two sync bytes, 16-bit checksum.
// Throughput: one byte per cycle while a frame is received; after the 32nd
// byte the input stalls while results are read out of the frame store.
// Readout: after the 32nd byte request, and after each result is taken, the
// controller steps through two store reads and a load that waits for a free output register.
// Reset (rst_n, synchronous): hunt state, checksum 0xFFFF, config defaults.
// Depends on rcsfd_pkg, rcsfd_ctrl, rcsfd_dp, rcsfd_ram.
module rc_servo_frame_decoder import rcsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // received byte requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // channel result requests
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel_index,
  output logic [15:0] out_channel_value,
  output logic        out_frame_ok,
  output logic        out_last
);

  rcsfd_cmd_t  cmd;
  rcsfd_stat_t stat;

  // Config writes are always taken; the user must send them only while idle (not enforced).
  assign cfg_ready = 1'b1;

  // Sequencer: receive bytes, then per channel read low byte, read high
  // byte, load the output register and, but for the last channel, wait for it to be taken.
  rcsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Sync hunt, checksum, frame store and the output register.
  rcsfd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_frame_ok      (out_frame_ok),
    .out_last          (out_last)
  );

endmodule
